// ===== rtl/overlay_window_clip_scale_assert.svh =====
// Assertion macros for the overlay window clip and scale RTL.
`ifndef OVERLAY_WINDOW_CLIP_SCALE_ASSERT_SVH
`define OVERLAY_WINDOW_CLIP_SCALE_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define OWCS_CHECK(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define OWCS_CHECK_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/owcs_pkg.sv =====
// Types and constants for the overlay window clip and scale pipeline.
package owcs_pkg;

    localparam int unsigned MIN_FACTOR = 800;
    localparam int unsigned SCALE_NUM  = 1000;
    localparam int unsigned QBITS      = 13;   // quotient bits, f >= 800
    localparam int unsigned NBITS      = 23;   // numerator bits
    localparam int unsigned LANES      = 4;    // px, w, cx, cw

    localparam logic REG_SCREEN_WIDTH  = 1'b0;
    localparam logic REG_SCREEN_HEIGHT = 1'b1;

    // after halving and left/top clip
    typedef struct packed {
        logic               ok;
        logic signed [11:0] px;
        logic        [11:0] w;
        logic        [9:0]  ox;
        logic        [11:0] f;
        logic signed [11:0] py;
        logic        [11:0] h;
        logic        [7:0]  oy;
        logic        [10:0] cx;
        logic signed [13:0] cw;
        logic        [10:0] cy;
        logic signed [13:0] ch;
    } clip_t;

    // divider stage payload
    typedef struct packed {
        logic                              ok;
        logic        [9:0]                 ox;
        logic        [11:0]                f;
        logic signed [11:0]                py;
        logic        [11:0]                h;
        logic        [7:0]                 oy;
        logic        [10:0]                cy;
        logic signed [13:0]                ch;
        logic [LANES-1:0]                  neg;
        logic [LANES-1:0][NBITS-1:0]       rem;
        logic [LANES-1:0][QBITS-1:0]       q;
    } div_t;

endpackage

// ===== rtl/overlay_window_clip_scale.sv =====
// Overlay window clip and scale: top level, 17-stage pipeline.
//
//  channel   | dir | contents
//  ----------+-----+---------------------------------------------------------
//  s_ (in)   | in  | window request: position, size, offsets, xcorr, double_y
//  m_ (out)  | out | valid_res + eight visible/frame edge coordinates
//  cfg_      | in  | screen_width (index 0), screen_height (index 1)
//
// One transaction enters per cycle while s_tready is high; 17 register
// stages lie between the input transaction and m_tvalid.
// Depth is set by the 13-step restoring divider (one quotient bit per
// stage, four lanes side by side) plus halve/clip, right/bottom clip,
// multiply and output.
// Each stage holds when its successor is full and stalled, so bubbles are
// squeezed out and nothing is lost or repeated under back-pressure.
// aresetn is synchronous; it clears valid bits and restores screen size.
module overlay_window_clip_scale (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // [11:0] pos_x, [23:12] pos_y, [35:24] win_width, [47:36] win_height,
    // [57:48] offset_x, [65:58] offset_y, [77:66] xcorr, [79:78] zero
    input  logic [79:0]  s_tdata,
    // [0] double_y
    input  logic [0:0]   s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // [13:0] visible_left, [27:14] visible_right, [41:28] visible_top,
    // [55:42] visible_bottom, [69:56] frame_left, [83:70] frame_right,
    // [97:84] frame_top, [111:98] frame_bottom
    output logic [111:0] m_tdata,
    // [0] valid_res
    output logic [0:0]   m_tuser,
    input  logic         cfg_we,
    input  logic [0:0]   cfg_addr,
    input  logic [11:0]  cfg_wdata
);
    import owcs_pkg::*;

    localparam int unsigned NST = 17;  // halve, clip, mul, 13 div, out
    localparam int unsigned DS  = 3;   // first divider step index

    logic [11:0] screen_width_reg, screen_height_reg;

    logic [NST-1:0] v_reg;
    logic [NST:0]   rdy;

    clip_t s1_reg, s1_next, s2_reg, s2_next;
    div_t  dv_reg [0:QBITS];
    div_t  dv_next [0:QBITS];
    logic [111:0] out_reg, out_next;
    logic         res_reg, res_next;

    // ---------------- configuration ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            screen_width_reg  <= 12'd1280;
            screen_height_reg <= 12'd1024;
        end else if (cfg_we) begin
            unique case (cfg_addr[0])
                REG_SCREEN_WIDTH:  screen_width_reg  <= cfg_wdata;
                REG_SCREEN_HEIGHT: screen_height_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // ---------------- stall chain ----------------
    // a stage may load when it is empty or its content moves on
    always_comb begin
        rdy[NST] = m_tready;
        for (int k = NST - 1; k >= 0; k--) begin
            rdy[k] = !v_reg[k] || rdy[k+1];
        end
    end

    assign s_tready = rdy[0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else begin
            if (rdy[0]) v_reg[0] <= s_tvalid;
            for (int k = 1; k < NST; k++) begin
                if (rdy[k]) begin
                    v_reg[k] <= v_reg[k-1];
                end
            end
        end
    end

    // ---------------- stage 1: halve, left/top clip ----------------
    always_comb begin
        logic               dbl;
        logic signed [11:0] py_in;
        logic        [11:0] h_in;
        logic        [7:0]  oy_in;
        dbl   = s_tuser[0];
        py_in = $signed(s_tdata[23:12]);
        h_in  = s_tdata[47:36];
        oy_in = s_tdata[65:58];
        s1_next.px = $signed(s_tdata[11:0]);
        s1_next.w  = s_tdata[35:24];
        s1_next.ox = s_tdata[57:48];
        s1_next.f  = s_tdata[77:66];
        s1_next.ok = (s_tdata[77:66] >= 12'(MIN_FACTOR));
        s1_next.py = dbl ? (py_in >>> 1) : py_in;
        s1_next.h  = dbl ? {1'b0, h_in[11:1]} : h_in;
        s1_next.oy = dbl ? {1'b0, oy_in[7:1]} : oy_in;
        if (s1_next.px < 0) begin
            s1_next.cx = '0;
            s1_next.cw = $signed({2'b00, s1_next.w}) + 14'(s1_next.px);
        end else begin
            s1_next.cx = s1_next.px[10:0];
            s1_next.cw = $signed({2'b00, s1_next.w});
        end
        if (s1_next.py < 0) begin
            s1_next.cy = '0;
            s1_next.ch = $signed({2'b00, s1_next.h}) + 14'(s1_next.py);
        end else begin
            s1_next.cy = s1_next.py[10:0];
            s1_next.ch = $signed({2'b00, s1_next.h});
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy[0]) s1_reg <= s1_next;
    end

    // ---------------- stage 2: right/bottom clip ----------------
    always_comb begin
        s2_next = s1_reg;
        if ($signed({4'b0, s1_reg.cx}) + $signed({s1_reg.cw[13], s1_reg.cw})
                > $signed({3'b0, screen_width_reg})) begin
            s2_next.cw = 14'($signed({2'b0, screen_width_reg}) - $signed({3'b0, s1_reg.cx}));
        end
        if ($signed({4'b0, s1_reg.cy}) + $signed({s1_reg.ch[13], s1_reg.ch})
                > $signed({3'b0, screen_height_reg})) begin
            s2_next.ch = 14'($signed({2'b0, screen_height_reg}) - $signed({3'b0, s1_reg.cy}));
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy[1]) s2_reg <= s2_next;
    end

    // ---------------- stage 3: magnitudes times 1000 ----------------
    always_comb begin
        logic [LANES-1:0][12:0] mag;
        logic signed [13:0] lv [LANES];
        lv[0] = 14'(s2_reg.px);
        lv[1] = $signed({2'b00, s2_reg.w});
        lv[2] = $signed({3'b000, s2_reg.cx});
        lv[3] = s2_reg.cw;
        dv_next[0].ok = s2_reg.ok;
        dv_next[0].ox = s2_reg.ox;
        dv_next[0].f  = s2_reg.f;
        dv_next[0].py = s2_reg.py;
        dv_next[0].h  = s2_reg.h;
        dv_next[0].oy = s2_reg.oy;
        dv_next[0].cy = s2_reg.cy;
        dv_next[0].ch = s2_reg.ch;
        dv_next[0].q  = '0;
        for (int j = 0; j < LANES; j++) begin
            dv_next[0].neg[j] = lv[j][13];
            mag[j] = lv[j][13] ? 13'(-lv[j]) : lv[j][12:0];
            dv_next[0].rem[j] = NBITS'(mag[j]) * NBITS'(SCALE_NUM);
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy[2]) dv_reg[0] <= dv_next[0];
    end

    // ---------------- stages 4..16: restoring divide ----------------
    for (genvar k = 1; k <= QBITS; k++) begin : g_div
        localparam int unsigned BIT = QBITS - k;
        always_comb begin
            logic [NBITS+1:0] dsh;
            dv_next[k] = dv_reg[k-1];
            dsh = (NBITS+2)'(dv_reg[k-1].f) << BIT;
            for (int j = 0; j < LANES; j++) begin
                if ({2'b00, dv_reg[k-1].rem[j]} >= dsh) begin
                    dv_next[k].rem[j]    = NBITS'({2'b00, dv_reg[k-1].rem[j]} - dsh);
                    dv_next[k].q[j][BIT] = 1'b1;
                end
            end
        end
        always_ff @(posedge aclk) begin
            if (rdy[DS+k-1]) dv_reg[k] <= dv_next[k];
        end
    end

    // ---------------- stage 17: offsets and edges ----------------
    always_comb begin
        logic signed [13:0] sq [LANES];
        logic [13:0] vl, vr, vt, vb, fl, fr, ft, fb;
        div_t d;
        d = dv_reg[QBITS];
        for (int j = 0; j < LANES; j++) begin
            sq[j] = d.neg[j] ? -$signed({1'b0, d.q[j]}) : $signed({1'b0, d.q[j]});
        end
        // lanes: 0 sx, 1 sw, 2 scx, 3 scw
        vl = 14'(d.ox) + sq[2];
        vr = vl + sq[3] - 14'd1;
        vt = 14'(d.oy) + 14'(d.cy);
        vb = vt + d.ch - 14'd1;
        fl = 14'(d.ox) + sq[0];
        fr = fl + sq[1] - 14'd1;
        ft = 14'(d.oy) + 14'(d.py);
        fb = ft + 14'(d.h) - 14'd1;
        res_next = d.ok;
        out_next = d.ok ? {fb, ft, fr, fl, vb, vt, vr, vl} : '0;
    end

    always_ff @(posedge aclk) begin
        if (rdy[NST-1]) begin
            out_reg <= out_next;
            res_reg <= res_next;
        end
    end

    assign m_tvalid   = v_reg[NST-1];
    assign m_tdata    = out_reg;
    assign m_tuser[0] = res_reg;

    // ---------------- checks ----------------
`include "overlay_window_clip_scale_assert.svh"

    `OWCS_CHECK(a_reject_zero, m_tvalid && !m_tuser[0], m_tdata == '0, "rejected window has edges")
    `OWCS_CHECK(a_out_stall, m_tvalid && !m_tready, !rdy[NST-1], "output stage not held on stall")
    `OWCS_CHECK_NEXT(a_enter, s_tvalid && s_tready, v_reg[0], "accepted transaction dropped")

endmodule

// ===== tb/overlay_window_clip_scale_tb.sv =====
// Testbench for the overlay window clip and scale pipeline.
module overlay_window_clip_scale_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import owcs_pkg::*;

    localparam int HALF_PERIOD  = 10;
    localparam int RESET_CYCLES = 11;
    localparam int N_RANDOM     = 930;
    localparam int LATENCY      = 17;
    localparam int STALL_LIMIT  = 20000;

    // One window request as the block sees it.
    typedef struct {
        logic signed [11:0] pos_x;
        logic signed [11:0] pos_y;
        logic        [11:0] win_width;
        logic        [11:0] win_height;
        logic        [9:0]  offset_x;
        logic        [7:0]  offset_y;
        logic        [11:0] xcorr;
        logic               double_y;
    } window_req_t;

    // One set of edges; the tuser bit followed by packed tdata.
    typedef struct {
        logic        valid_res;
        logic [13:0] edges [8];
    } edge_set_t;

    // Scoreboard: predicts edges for each accepted request and compares
    // each accepted result against the oldest pending one.
    class edge_scoreboard;
        logic [11:0] scr_w;
        logic [11:0] scr_h;
        edge_set_t   pending_edges [$];
        int          errors;

        function new();
            scr_w  = 12'd1280;
            scr_h  = 12'd1024;
            errors = 0;
        endfunction

        function void set_screen(logic [0:0] idx, logic [11:0] val);
            if (idx == REG_SCREEN_WIDTH) scr_w = val;
            else scr_h = val;
        endfunction

        function edge_set_t compute_edges(window_req_t r);
            edge_set_t e;
            longint px, py, w, h, ox, oy, f, cx, cy, cw, ch, sx, sw, scx, scw;
            longint num;
            longint vals [8];
            num = SCALE_NUM;
            px = r.pos_x;  py = r.pos_y;
            w  = r.win_width;  h = r.win_height;
            ox = r.offset_x;   oy = r.offset_y;  f = r.xcorr;
            e.valid_res = 1'b0;
            for (int i = 0; i < 8; i++) e.edges[i] = '0;
            if (f < MIN_FACTOR) return e;
            if (r.double_y) begin
                py = py >>> 1;   // rounds toward minus infinity
                h  = h / 2;
                oy = oy / 2;
            end
            if (px < 0) begin
                cx = 0;  cw = w + px;
            end else begin
                cx = px; cw = w;
            end
            if (py < 0) begin
                cy = 0;  ch = h + py;
            end else begin
                cy = py; ch = h;
            end
            if (cx + cw > longint'(scr_w)) cw = longint'(scr_w) - cx;
            if (cy + ch > longint'(scr_h)) ch = longint'(scr_h) - cy;
            // signed integer division truncates toward zero
            sx  = (px * num) / f;
            sw  = (w * num) / f;
            scx = (cx * num) / f;
            scw = (cw * num) / f;
            vals[0] = ox + scx;
            vals[1] = ox + scx + scw - 1;
            vals[2] = oy + cy;
            vals[3] = oy + cy + ch - 1;
            vals[4] = ox + sx;
            vals[5] = ox + sx + sw - 1;
            vals[6] = oy + py;
            vals[7] = oy + py + h - 1;
            e.valid_res = 1'b1;
            for (int i = 0; i < 8; i++) e.edges[i] = vals[i][13:0];
            return e;
        endfunction

        function void note_request(window_req_t r);
            pending_edges.push_back(compute_edges(r));
        endfunction

        task check_result(logic vr, logic [111:0] data);
            edge_set_t exp_e;
            if (pending_edges.size() == 0) begin
                report_mismatch("result with no request pending");
                return;
            end
            exp_e = pending_edges.pop_front();
            if (vr !== exp_e.valid_res)
                report_mismatch($sformatf("valid_res got %0b want %0b", vr,
                                          exp_e.valid_res));
            for (int i = 0; i < 8; i++)
                if (data[14*i +: 14] !== exp_e.edges[i])
                    report_mismatch($sformatf("edge %0d got %0h want %0h", i,
                                              data[14*i +: 14], exp_e.edges[i]));
        endtask

        task report_mismatch(string msg);
            errors++;
            $display("MISMATCH at %0t: %s", $realtime, msg);
        endtask
    endclass

    logic         aclk;
    logic         aresetn;
    logic         s_tvalid;
    logic         s_tready;
    logic [79:0]  s_tdata;    // pos_x, pos_y, win_width, win_height, offset_x,
                              // offset_y, xcorr, zero pad (lowest first)
    logic [0:0]   s_tuser;    // double_y
    logic         m_tvalid;
    logic         m_tready;
    logic [111:0] m_tdata;    // visible l/r/t/b, frame l/r/t/b (lowest first)
    logic [0:0]   m_tuser;    // valid_res
    logic         cfg_we;
    logic [0:0]   cfg_addr;
    logic [11:0]  cfg_wdata;

    edge_scoreboard sb;
    int  idle_pct;          // idle percentage on both sides; 0 = busy stretch
    bit  hold_sink;         // long receiver hold-off requested
    int  quiet_cycles;
    bit  stim_done;

    overlay_window_clip_scale i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    initial aclk = 1'b0;
    always #HALF_PERIOD aclk = ~aclk;

    initial begin
        aresetn   = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = '0;
        m_tready  = 1'b0;
        cfg_we    = 1'b0;
        cfg_addr  = '0;
        cfg_wdata = '0;
    end

    // Receiver: random stalls, plus a long hold-off when asked.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            m_tready <= !hold_sink && ($urandom_range(99) >= idle_pct);
        end
    end

    // Check every accepted result transaction.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            sb.check_result(m_tuser[0], m_tdata);
    end

    // Watchdog: cycles with no transaction on either side.
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !aresetn)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > STALL_LIMIT) begin
            $display("overlay_window_clip_scale_tb failed");
            $finish;
        end
    end

    // One register write, after which the write port is left idle before the task returns.
    task automatic write_reg(logic [0:0] idx, logic [11:0] val);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_we    <= 1'b0;
        sb.set_screen(idx, val);
        @(posedge aclk);
    endtask

    // Offer one request; valid stays high back to back when no gap is drawn.
    task automatic send_request(window_req_t r);
        while ($urandom_range(99) < idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {2'b00, r.xcorr, r.offset_y, r.offset_x, r.win_height,
                     r.win_width, r.pos_y, r.pos_x};
        s_tuser  <= r.double_y;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sb.note_request(r);
    endtask

    // Drop valid and wait until every expected result has been seen.
    task automatic drain_results();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (sb.pending_edges.size() != 0) @(posedge aclk);
        repeat (LATENCY + 3) @(posedge aclk);
    endtask

    function automatic window_req_t make_req(int px, int py, int w, int h,
                                             int ox, int oy, int f, bit dbl);
        window_req_t r;
        r.pos_x = 12'(px);  r.pos_y = 12'(py);
        r.win_width = 12'(w);  r.win_height = 12'(h);
        r.offset_x = 10'(ox);  r.offset_y = 8'(oy);
        r.xcorr = 12'(f);  r.double_y = dbl;
        return r;
    endfunction

    // Mostly valid factors and on-screen sizes; some noise over full ranges.
    function automatic window_req_t random_req();
        window_req_t r;
        int k;
        k = $urandom_range(99);
        r.pos_x      = 12'($urandom);
        r.pos_y      = 12'($urandom);
        r.win_width  = (k < 70) ? 12'($urandom_range(2048)) : 12'($urandom);
        r.win_height = (k < 70) ? 12'($urandom_range(2048)) : 12'($urandom);
        r.offset_x   = 10'($urandom);
        r.offset_y   = 8'($urandom);
        r.xcorr      = (k < 85) ? 12'($urandom_range(4095, 800)) : 12'($urandom);
        r.double_y   = 1'($urandom);
        if (k < 40) begin
            r.pos_x = 12'(int'($urandom_range(1400)) - 200);
            r.pos_y = 12'(int'($urandom_range(1100)) - 100);
        end
        return r;
    endfunction

    initial begin
        logic [11:0] widths  [4] = '{12'd0, 12'd4095, 12'd640, 12'd1920};
        logic [11:0] heights [4] = '{12'd4095, 12'd0, 12'd480, 12'd1080};
        sb           = new();
        idle_pct     = 11;
        hold_sink    = 1'b0;
        quiet_cycles = 0;
        stim_done    = 1'b0;
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: reset screen size, field extremes and each special case.
        send_request(make_req(0, 0, 0, 0, 0, 0, 0, 0));            // factor zero
        send_request(make_req(100, 100, 50, 50, 5, 5, 799, 1));    // just below 800
        send_request(make_req(100, 100, 50, 50, 5, 5, 800, 0));    // exactly 800
        send_request(make_req(-2048, -2048, 2048, 2048, 1023, 255, 800, 0));
        send_request(make_req(2047, 2047, 2048, 2048, 1023, 255, 4095, 1));
        send_request(make_req(-300, -7, 100, 3, 0, 0, 1000, 1));  // size goes negative
        send_request(make_req(-1, -1, 1, 1, 0, 255, 1000, 1));    // odd negative halve
        send_request(make_req(-3, -5, 4095, 4095, 1, 255, 3000, 1));
        send_request(make_req(1200, 1000, 500, 500, 7, 9, 1000, 0)); // past edges
        send_request(make_req(-50, 900, 2000, 300, 10, 20, 1234, 0));
        send_request(make_req(0, 0, 1280, 1024, 0, 0, 1000, 0));
        send_request(make_req(-1000, 500, 1, 4095, 1023, 0, 801, 0));
        send_request(make_req(2047, -2048, 4095, 0, 0, 1, 4095, 1));
        send_request(make_req(600, 400, 640, 480, 512, 128, 1500, 1));
        drain_results();

        // Phases over several screen sizes, extremes first.
        for (int ph = 0; ph < 4; ph++) begin
            write_reg(REG_SCREEN_WIDTH, widths[ph]);
            write_reg(REG_SCREEN_HEIGHT, heights[ph]);
            // one busy stretch with no idling in the second phase
            idle_pct = (ph == 1) ? 0 : 11;
            for (int i = 0; i < N_RANDOM / 4; i++) begin
                if (ph == 2 && i == 20) hold_sink = 1'b1;  // receiver holds off
                if (ph == 2 && i == 60) hold_sink = 1'b0;
                send_request(random_req());
            end
            drain_results();
        end
        stim_done = 1'b1;
    end

    // Long receiver hold-off is released by count too, in case the sender blocks.
    initial begin
        wait (hold_sink);
        repeat (300) @(posedge aclk);
        hold_sink = 1'b0;
    end

    initial begin
        wait (stim_done);
        repeat (LATENCY + 5) @(posedge aclk);
        if (sb.errors == 0 && sb.pending_edges.size() == 0)
            $display("overlay_window_clip_scale_tb passed");
        else
            $display("overlay_window_clip_scale_tb failed");
        $finish;
    end
endmodule

// ===== sim.f =====
+incdir+rtl
rtl/owcs_pkg.sv
rtl/overlay_window_clip_scale.sv
tb/overlay_window_clip_scale_tb.sv
